@@ src/sva_pkg.sv @@
// Shared types and constants for the sound voice allocator.
// Used by sva_ctrl, sva_datapath and sound_voice_allocator; depends on nothing.
package sva_pkg;

  localparam int NUM_VOICES = 16;
  localparam int VOICE_W    = $clog2(NUM_VOICES);
  localparam int CNT_W      = $clog2(NUM_VOICES + 1);

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int VOL_W      = 8;
  localparam int FRAME_W    = 32;
  localparam int PROD_W     = GAIN_W + VOL_W;

  // floor(p / 100) == (p * DIV100_MAGIC) >> DIV100_SHIFT for any 32-bit p
  localparam int          DIV100_SHIFT = 37;
  localparam logic [30:0] DIV100_MAGIC = 31'd1374389535;
  localparam int          MULT_W       = PROD_W + 31;
  localparam int          QUOT_W       = MULT_W - DIV100_SHIFT;

  localparam logic [VOL_W-1:0] REUSE_TOL_RESET = 8'd10;

  localparam logic OPC_PLAY  = 1'b0;
  localparam logic OPC_SWEEP = 1'b1;

  typedef enum logic [1:0] {
    ACT_DROP   = 2'd0,
    ACT_START  = 2'd1,
    ACT_ADJUST = 2'd2,
    ACT_STOP   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_START,
    OP_SCAN_NEXT,
    OP_ADJUST,
    OP_TAKE,
    OP_LINK1,
    OP_LINK2,
    OP_ONESHOT,
    OP_KEEP,
    OP_UNLINK0,
    OP_UNLINK1,
    OP_UNLINK2,
    OP_PEND
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_TAKE,
    ST_LINK1,
    ST_LINK2,
    ST_ONESHOT,
    ST_EMIT_DROP,
    ST_EMIT_START,
    ST_EMIT_ADJ,
    ST_WALK,
    ST_UNLINK1,
    ST_UNLINK2,
    ST_PEND,
    ST_FINAL
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    logic    rd_ring;   // link read port addresses the ring head, else cur
    logic    emit;
    action_t action;
    logic    last;
  } sva_cmd_t;

  typedef struct packed {
    logic op_sweep;
    logic loops;
    logic cnt_zero;
    logic match;
    logic stale;
    logic ring_single;
    logic pend_valid;
    logic out_free;
  } sva_status_t;

endpackage

@@ src/sva_ctrl.sv @@
// Controller state machine of the voice allocator.
// Depends on sva_pkg; drives sva_datapath through sva_cmd_t.
module sva_ctrl
  import sva_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sva_status_t status,
  output sva_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.op      = OP_IDLE;
    cmd.rd_ring = 1'b0;
    cmd.emit    = 1'b0;
    cmd.action  = ACT_DROP;
    cmd.last    = 1'b0;
    in_ready    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.op     = OP_START;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.op_sweep) begin
          state_next = ST_WALK;
        end else if (status.loops) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_TAKE;
        end
      end
      ST_SCAN: begin
        if (status.cnt_zero) begin
          state_next = ST_TAKE;
        end else if (status.match) begin
          cmd.op     = OP_ADJUST;
          state_next = ST_EMIT_ADJ;
        end else begin
          cmd.op = OP_SCAN_NEXT;
        end
      end
      ST_TAKE: begin
        cmd.rd_ring = 1'b1;
        cmd.op      = OP_TAKE;
        if (status.ring_single) begin
          state_next = ST_EMIT_DROP;
        end else if (status.loops) begin
          state_next = ST_LINK1;
        end else begin
          state_next = ST_ONESHOT;
        end
      end
      ST_LINK1: begin
        cmd.op     = OP_LINK1;
        state_next = ST_LINK2;
      end
      ST_LINK2: begin
        cmd.op     = OP_LINK2;
        state_next = ST_EMIT_START;
      end
      ST_ONESHOT: begin
        cmd.op     = OP_ONESHOT;
        state_next = ST_EMIT_START;
      end
      ST_EMIT_DROP: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.action = ACT_DROP;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_START: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.action = ACT_START;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_ADJ: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.action = ACT_ADJUST;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (status.cnt_zero) begin
          state_next = ST_FINAL;
        end else if (status.stale) begin
          cmd.op     = OP_UNLINK0;
          state_next = ST_UNLINK1;
        end else begin
          cmd.op = OP_KEEP;
        end
      end
      ST_UNLINK1: begin
        cmd.rd_ring = 1'b1;
        cmd.op      = OP_UNLINK1;
        state_next  = ST_UNLINK2;
      end
      ST_UNLINK2: begin
        cmd.op     = OP_UNLINK2;
        state_next = ST_PEND;
      end
      ST_PEND: begin
        // hold the newest stop back so the final one can carry last
        if (!status.pend_valid) begin
          cmd.op     = OP_PEND;
          state_next = ST_WALK;
        end else if (status.out_free) begin
          cmd.op     = OP_PEND;
          cmd.emit   = 1'b1;
          cmd.action = ACT_STOP;
          state_next = ST_WALK;
        end
      end
      ST_FINAL: begin
        if (!status.pend_valid) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.action = ACT_STOP;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/sva_datapath.sv @@
// Datapath of the voice allocator: link table, voice records, gain unit,
// list pointers and the output register. Depends on sva_pkg.
module sva_datapath
  import sva_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  sva_cmd_t            cmd,
  output sva_status_t         status,
  input  logic                cfg_wr_en,
  input  logic [VOL_W-1:0]    cfg_wr_data,
  input  logic                opcode,
  input  logic [SAMPLE_W-1:0] sample_id,
  input  logic                sample_loops,
  input  logic [GAIN_W-1:0]   sample_gain,
  input  logic [VOL_W-1:0]    volume,
  input  logic [FRAME_W-1:0]  frame_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          action,
  output logic [VOICE_W-1:0]  voice,
  output logic [SAMPLE_W-1:0] out_sample_id,
  output logic                out_loop,
  output logic [GAIN_W-1:0]   gain,
  output logic                last
);

  logic [VOICE_W-1:0]  next_link    [NUM_VOICES];
  logic [SAMPLE_W-1:0] voice_sample [NUM_VOICES];
  logic [VOL_W-1:0]    voice_volume [NUM_VOICES];
  logic [FRAME_W-1:0]  voice_stamp  [NUM_VOICES];

  logic [VOL_W-1:0]    thr;
  logic [VOICE_W-1:0]  ring_head;
  logic [VOICE_W-1:0]  loop_head;
  logic [CNT_W-1:0]    loop_count;
  logic                pend_valid;

  logic                op_r;
  logic                lp_r;
  logic [SAMPLE_W-1:0] sid_r;
  logic [VOL_W-1:0]    vol_r;
  logic [FRAME_W-1:0]  frame_r;
  logic [PROD_W-1:0]   prod;
  logic [MULT_W-1:0]   mult;
  logic [VOICE_W-1:0]  cur;
  logic [VOICE_W-1:0]  prev;
  logic                has_prev;
  logic [VOICE_W-1:0]  nxt_r;
  logic [CNT_W-1:0]    cnt;
  logic [VOICE_W-1:0]  pend_voice;
  logic [SAMPLE_W-1:0] pend_sample;

  logic [VOICE_W-1:0]  rd_addr;
  logic [VOICE_W-1:0]  rd_link;
  logic [SAMPLE_W-1:0] cur_sample;
  logic [VOL_W-1:0]    cur_vol;
  logic [FRAME_W-1:0]  age;
  logic [VOL_W-1:0]    vol_diff;
  logic [QUOT_W-1:0]   quot;
  logic [GAIN_W-1:0]   gain_sat;

  logic                link_we;
  logic [VOICE_W-1:0]  link_waddr;
  logic [VOICE_W-1:0]  link_wdata;
  logic                info_we;
  logic                sample_we;

  // single read port on each table
  assign rd_addr    = cmd.rd_ring ? ring_head : cur;
  assign rd_link    = next_link[rd_addr];
  assign cur_sample = voice_sample[cur];
  assign cur_vol    = voice_volume[cur];
  assign age        = frame_r - voice_stamp[cur];
  assign vol_diff   = (cur_vol > vol_r) ? (cur_vol - vol_r) : (vol_r - cur_vol);

  // gain = floor(sample_gain * volume / 100), clipped to the Q4.12 range
  assign quot     = mult[MULT_W-1:DIV100_SHIFT];
  assign gain_sat = (|quot[QUOT_W-1:GAIN_W]) ? {GAIN_W{1'b1}} : quot[GAIN_W-1:0];

  assign status.op_sweep    = (op_r == OPC_SWEEP);
  assign status.loops       = lp_r;
  assign status.cnt_zero    = (cnt == '0);
  assign status.match       = (cur_sample == sid_r) && (vol_diff < thr);
  assign status.stale       = (age > FRAME_W'(1));
  assign status.ring_single = (rd_link == ring_head);
  assign status.pend_valid  = pend_valid;
  assign status.out_free    = !out_valid || out_ready;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur;
    link_wdata = rd_link;
    info_we    = 1'b0;
    sample_we  = 1'b0;
    case (cmd.op)
      OP_LINK1: begin
        link_we    = 1'b1;
        link_waddr = ring_head;
      end
      OP_LINK2: begin
        link_we    = 1'b1;
        link_wdata = loop_head;
        info_we    = 1'b1;
        sample_we  = 1'b1;
      end
      OP_ONESHOT: begin
        info_we   = 1'b1;
        sample_we = 1'b1;
      end
      OP_ADJUST: begin
        info_we = 1'b1;
      end
      OP_UNLINK0: begin
        link_we    = has_prev;
        link_waddr = prev;
      end
      OP_UNLINK1: begin
        link_we = 1'b1;
      end
      OP_UNLINK2: begin
        link_we    = 1'b1;
        link_waddr = ring_head;
        link_wdata = cur;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        next_link[i]    <= VOICE_W'((i + 1) % NUM_VOICES);
        voice_volume[i] <= '0;
        voice_stamp[i]  <= '0;
      end
    end else begin
      if (link_we) begin
        next_link[link_waddr] <= link_wdata;
      end
      if (info_we) begin
        voice_volume[cur] <= vol_r;
        voice_stamp[cur]  <= frame_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_we) begin
      voice_sample[cur] <= sid_r;
    end
  end

  // list pointers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      thr        <= REUSE_TOL_RESET;
      ring_head  <= '0;
      loop_head  <= '0;
      loop_count <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr <= cfg_wr_data;
      end
      case (cmd.op)
        OP_START: begin
          pend_valid <= 1'b0;
        end
        OP_LINK2: begin
          loop_head  <= cur;
          loop_count <= loop_count + CNT_W'(1);
        end
        OP_ONESHOT: begin
          ring_head <= cur;
        end
        OP_UNLINK0: begin
          if (!has_prev) begin
            loop_head <= rd_link;
          end
        end
        OP_UNLINK2: begin
          loop_count <= loop_count - CNT_W'(1);
        end
        OP_PEND: begin
          pend_valid <= 1'b1;
        end
        default: begin
          pend_valid <= pend_valid;
        end
      endcase
    end
  end

  // request word, walk cursor and gain pipeline
  always_ff @(posedge clk) begin
    mult <= prod * DIV100_MAGIC;
    case (cmd.op)
      OP_START: begin
        op_r     <= opcode;
        lp_r     <= sample_loops;
        sid_r    <= sample_id;
        vol_r    <= volume;
        frame_r  <= frame_count;
        prod     <= sample_gain * volume;
        cur      <= loop_head;
        cnt      <= loop_count;
        has_prev <= 1'b0;
      end
      OP_SCAN_NEXT: begin
        cur <= rd_link;
        cnt <= cnt - CNT_W'(1);
      end
      OP_TAKE: begin
        cur <= rd_link;
      end
      OP_KEEP: begin
        prev     <= cur;
        has_prev <= 1'b1;
        cur      <= rd_link;
        cnt      <= cnt - CNT_W'(1);
      end
      OP_UNLINK0: begin
        nxt_r <= rd_link;
      end
      OP_PEND: begin
        pend_voice  <= cur;
        pend_sample <= cur_sample;
        cur         <= nxt_r;
        cnt         <= cnt - CNT_W'(1);
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      action <= cmd.action;
      last   <= cmd.last;
      case (cmd.action)
        ACT_START: begin
          voice         <= cur;
          out_sample_id <= sid_r;
          out_loop      <= lp_r;
          gain          <= gain_sat;
        end
        ACT_ADJUST: begin
          voice         <= cur;
          out_sample_id <= sid_r;
          out_loop      <= 1'b1;
          gain          <= gain_sat;
        end
        ACT_STOP: begin
          voice         <= pend_voice;
          out_sample_id <= pend_sample;
          out_loop      <= 1'b1;
          gain          <= '0;
        end
        default: begin
          voice         <= '0;
          out_sample_id <= '0;
          out_loop      <= 1'b0;
          gain          <= '0;
        end
      endcase
    end
  end

endmodule

@@ src/sound_voice_allocator.sv @@
// Top level of the sound voice allocator.
// Depends on sva_pkg, sva_ctrl and sva_datapath.
//
// Usage: a request word (opcode, sample_id, sample_loops, sample_gain, volume,
// frame_count) enters on in_valid/in_ready. A play request yields exactly one
// result word: start, adjust gain of a reused looping voice, or dropped when
// the free ring is down to one voice. A frame-update request yields one stop
// word per stale looping voice, or none at all. The final word of a request
// carries last. Result words leave on out_valid/out_ready from an output
// register; a stalled receiver holds the block in its emit step.
// Steps: a looping play first walks the looping list for a reuse match; a
// play without one then takes the voice after the ring head, or is dropped
// when the ring holds one voice. A sweep walks the looping list, relinks each
// stale voice after the ring head and emits its stop word. The walk is set by
// the single link read port, one hop per cycle while no word waits on a
// stalled receiver; a stale voice also takes link rewrites.
// in_ready is high only while out of reset and no request is in work.
// Reset: all voices sit in one ring headed by voice 0, the looping list is
// empty, stamps and volumes are zero and the reuse tolerance returns to 10;
// write it through cfg_wr_en/cfg_wr_data while idle.
module sound_voice_allocator
  import sva_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [VOL_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                opcode,
  input  logic [SAMPLE_W-1:0] sample_id,
  input  logic                sample_loops,
  input  logic [GAIN_W-1:0]   sample_gain,
  input  logic [VOL_W-1:0]    volume,
  input  logic [FRAME_W-1:0]  frame_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          action,
  output logic [VOICE_W-1:0]  voice,
  output logic [SAMPLE_W-1:0] out_sample_id,
  output logic                out_loop,
  output logic [GAIN_W-1:0]   gain,
  output logic                last
);

  sva_cmd_t    cmd;
  sva_status_t status;

  // sequence the walk: one list hop or link rewrite per cycle unless stalled
  sva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // tables, pointers, gain unit and the output word register
  sva_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .opcode        (opcode),
    .sample_id     (sample_id),
    .sample_loops  (sample_loops),
    .sample_gain   (sample_gain),
    .volume        (volume),
    .frame_count   (frame_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .voice         (voice),
    .out_sample_id (out_sample_id),
    .out_loop      (out_loop),
    .gain          (gain),
    .last          (last)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking bench for sound_voice_allocator: directed table, then random phases.
// Predicts each result word from its own model of the voice ring and looping list.
// Depends on sva_pkg and the RTL of the block only.
module tb;
  import sva_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int DRAIN_CYCLES  = 40;    // time for a sweep that stops nothing to finish
  localparam int SQUEEZE_LEN   = 400;   // long receiver hold-off, in cycles
  localparam int PHASE_WORDS   = 49;
  localparam int STOP_REPORTS  = 16;    // cap on stops reported per sweep
  localparam int NUM_PHASES    = 4;

  // One request word as it crosses the input channel.
  typedef struct packed {
    logic                opc;
    logic [SAMPLE_W-1:0] sid;
    logic                loops;
    logic [GAIN_W-1:0]   sgain;
    logic [VOL_W-1:0]    vol;
    logic [FRAME_W-1:0]  frame;
  } sound_req_t;

  // One result word as it leaves the output channel.
  typedef struct packed {
    action_t             act;
    logic [VOICE_W-1:0]  vc;
    logic [SAMPLE_W-1:0] sid;
    logic                loops;
    logic [GAIN_W-1:0]   gn;
    logic                lst;
  } voice_evt_t;

  // Directed row: n_typed < 0 takes the predicted words, otherwise n_typed
  // words (0 or 1) are read off the row itself.
  typedef struct {
    sound_req_t req;
    int         n_typed;
    voice_evt_t typed;
  } dir_row_t;

  localparam voice_evt_t NO_EVT = '0;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [VOL_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                opcode = OPC_PLAY;
  logic [SAMPLE_W-1:0] sample_id = '0;
  logic                sample_loops = 1'b0;
  logic [GAIN_W-1:0]   sample_gain = '0;
  logic [VOL_W-1:0]    volume = '0;
  logic [FRAME_W-1:0]  frame_count = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          action;
  logic [VOICE_W-1:0]  voice;
  logic [SAMPLE_W-1:0] out_sample_id;
  logic                out_loop;
  logic [GAIN_W-1:0]   gain;
  logic                last;

  sound_voice_allocator DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .sample_id(sample_id), .sample_loops(sample_loops),
    .sample_gain(sample_gain), .volume(volume), .frame_count(frame_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .action(action), .voice(voice), .out_sample_id(out_sample_id),
    .out_loop(out_loop), .gain(gain), .last(last)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Allocator model: ring of free/one-shot voices, list of looping voices
  // ---------------------------------------------------------------------
  logic [VOICE_W-1:0]  lnk     [NUM_VOICES];
  logic [VOICE_W-1:0]  ring_hd;
  logic [VOICE_W-1:0]  loop_hd;
  int                  loop_cnt;
  logic [SAMPLE_W-1:0] v_sid   [NUM_VOICES];
  logic [VOL_W-1:0]    v_vol   [NUM_VOICES];
  logic [FRAME_W-1:0]  v_stamp [NUM_VOICES];
  logic [VOL_W-1:0]    thr;

  voice_evt_t fresh_evts[$];   // words caused by the request just accepted
  voice_evt_t exp_evts[$];     // words still owed by the block, oldest first
  int         n_err = 0;

  // Q4.12 gain scaled by volume/100, truncated, saturated at the top.
  function automatic logic [GAIN_W-1:0] scaled_gain(logic [GAIN_W-1:0] sg,
                                                    logic [VOL_W-1:0] v);
    longint unsigned q;
    q = sg * v;
    q = q / 100;
    return (q > 65535) ? '1 : q[GAIN_W-1:0];
  endfunction

  // Apply one request to the model; leave the words it causes in fresh_evts.
  task automatic step_alloc(input sound_req_t r);
    logic [VOICE_W-1:0] cur, prv, nxt, v;
    logic [VOL_W-1:0]   d;
    logic [FRAME_W-1:0] age;
    logic               has_prv;
    voice_evt_t         ev;
    bit                 have_ev;
    int                 n, reported;
    fresh_evts.delete();
    if (r.opc == OPC_PLAY) begin
      // Reuse a looping voice of the same sample at a close enough volume.
      if (r.loops) begin
        cur = loop_hd;
        for (int i = 0; i < loop_cnt; i++) begin
          d = (v_vol[cur] > r.vol) ? v_vol[cur] - r.vol : r.vol - v_vol[cur];
          if (v_sid[cur] == r.sid && d < thr) begin
            v_vol[cur]   = r.vol;
            v_stamp[cur] = r.frame;
            fresh_evts.push_back('{ACT_ADJUST, cur, r.sid, 1'b1,
                                   scaled_gain(r.sgain, r.vol), 1'b1});
            return;
          end
          cur = lnk[cur];
        end
      end
      v = lnk[ring_hd];
      // Ring down to one voice: drop the request.
      if (v == ring_hd) begin
        fresh_evts.push_back('{ACT_DROP, '0, '0, 1'b0, '0, 1'b1});
        return;
      end
      if (r.loops) begin
        lnk[ring_hd] = lnk[v];
        lnk[v]       = loop_hd;
        loop_hd      = v;
        loop_cnt++;
      end else begin
        ring_hd = v;
      end
      v_sid[v]   = r.sid;
      v_vol[v]   = r.vol;
      v_stamp[v] = r.frame;
      fresh_evts.push_back('{ACT_START, v, r.sid, r.loops,
                             scaled_gain(r.sgain, r.vol), 1'b1});
    end else begin
      // Sweep: stop stale looping voices and relink them after the ring head.
      n        = loop_cnt;
      cur      = loop_hd;
      prv      = '0;
      has_prv  = 1'b0;
      have_ev  = 1'b0;
      reported = 0;
      for (int i = 0; i < n; i++) begin
        nxt = lnk[cur];
        age = r.frame - v_stamp[cur];   // wrap-safe age
        if (age > 1) begin
          if (has_prv) lnk[prv] = nxt;
          else loop_hd = nxt;
          lnk[cur]     = lnk[ring_hd];
          lnk[ring_hd] = cur;
          loop_cnt--;
          if (reported < STOP_REPORTS) begin
            if (have_ev) fresh_evts.push_back(ev);
            ev      = '{ACT_STOP, cur, v_sid[cur], 1'b1, '0, 1'b0};
            have_ev = 1'b1;
            reported++;
          end
        end else begin
          prv     = cur;
          has_prv = 1'b1;
        end
        cur = nxt;
      end
      // Mark the final stop word; a sweep that stops nothing owes no word.
      if (have_ev) begin
        ev.lst = 1'b1;
        fresh_evts.push_back(ev);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------
  voice_evt_t want_evt;

  task automatic check_field(input string nm, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", nm, want, got);
      n_err++;
    end
  endtask

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (exp_evts.size() == 0) begin
        $error("result word with no expectation: action %0d voice %0d", action, voice);
        n_err++;
      end else begin
        want_evt = exp_evts.pop_front();
        check_field("action", want_evt.act, action);
        check_field("voice", want_evt.vc, voice);
        check_field("out_sample_id", want_evt.sid, out_sample_id);
        check_field("out_loop", want_evt.loops, out_loop);
        check_field("gain", want_evt.gn, gain);
        check_field("last", want_evt.lst, last);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stall patterns of its own, plus one long hold-off on request
  // ---------------------------------------------------------------------
  logic squeeze_req = 1'b0;
  int   squeeze_cnt = 0;
  int   pat_left = 0;
  int   pat_mode = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (squeeze_req && squeeze_cnt < SQUEEZE_LEN) begin
      // Hold off long enough for the output register to fill and in_ready to drop.
      out_ready   <= 1'b0;
      squeeze_cnt <= squeeze_cnt + 1;
    end else begin
      if (pat_left == 0) begin
        pat_mode <= $urandom_range(0, 3);
        pat_left <= $urandom_range(16, 80);
      end else begin
        pat_left <= pat_left - 1;
      end
      case (pat_mode)
        0: out_ready <= 1'b1;                          // no stalls
        1: out_ready <= 1'($urandom_range(0, 1));      // coin flip
        2: out_ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
        default: out_ready <= pat_left[0];             // toggles with pat_left
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Run limit
  // ---------------------------------------------------------------------
  int cyc = 0;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  int                  burst_left = 0;
  logic [FRAME_W-1:0]  fr;
  logic [SAMPLE_W-1:0] pool_sid [4];
  logic [VOL_W-1:0]    pool_vol [4];
  dir_row_t            dir_rows[$];

  function automatic sound_req_t mk_req(logic opc, logic [SAMPLE_W-1:0] sid, logic lp,
                                        logic [GAIN_W-1:0] sg, logic [VOL_W-1:0] vol,
                                        logic [FRAME_W-1:0] frame);
    return '{opc, sid, lp, sg, vol, frame};
  endfunction

  function automatic voice_evt_t mk_evt(action_t a, logic [VOICE_W-1:0] vc,
                                        logic [SAMPLE_W-1:0] sid, logic lp,
                                        logic [GAIN_W-1:0] gn);
    return '{a, vc, sid, lp, gn, 1'b1};
  endfunction

  task automatic add_row(input sound_req_t r, input int n, input voice_evt_t t);
    dir_rows.push_back('{r, n, t});
  endtask

  // Offer one word, hold it until accepted, then book what it owes.
  task automatic send_word(input sound_req_t r, input int n_typed, input voice_evt_t typed);
    in_valid     <= 1'b1;
    opcode       <= r.opc;
    sample_id    <= r.sid;
    sample_loops <= r.loops;
    sample_gain  <= r.sgain;
    volume       <= r.vol;
    frame_count  <= r.frame;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    step_alloc(r);
    if (n_typed < 0) begin
      foreach (fresh_evts[i]) exp_evts.push_back(fresh_evts[i]);
    end else if (n_typed > 0) begin
      exp_evts.push_back(typed);
    end
  endtask

  // Bursts of back-to-back words separated by random gaps.
  task automatic pace_sender();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Mostly well-formed traffic: looping requests from a small pool of samples
  // at nearby volumes so reuse happens, one-shots, sweeps on an advancing
  // frame, and a share of noise words with any content.
  task automatic pick_req(output sound_req_t r);
    int k, j;
    k        = $urandom_range(0, 99);
    r.opc    = OPC_PLAY;
    r.sid    = SAMPLE_W'($urandom);
    r.loops  = 1'b0;
    r.sgain  = GAIN_W'($urandom);
    r.vol    = VOL_W'($urandom);
    if (k < 18) begin
      fr      = fr + $urandom_range(0, 3);
      r.opc   = OPC_SWEEP;
      r.loops = 1'($urandom_range(0, 1));
    end else if (k < 55) begin
      j       = $urandom_range(0, 3);
      r.sid   = pool_sid[j];
      r.loops = 1'b1;
      r.vol   = VOL_W'(pool_vol[j] + $urandom_range(0, 24) - 12);
    end else if (k < 65) begin
      r.loops = 1'b1;
    end
    r.frame = fr;
    if (k >= 92) begin
      r.opc   = 1'($urandom_range(0, 1));
      r.loops = 1'($urandom_range(0, 1));
      r.frame = $urandom;
    end
  endtask

  // Wait out every owed word and any silent sweep still in work.
  task automatic drain();
    while (exp_evts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  logic [VOL_W-1:0] thr_plan [NUM_PHASES];
  sound_req_t       req;

  initial begin
    // Model state after reset: one ring headed by voice 0, no looping voices.
    for (int i = 0; i < NUM_VOICES; i++) begin
      lnk[i]     = VOICE_W'(i + 1);
      v_sid[i]   = '0;
      v_vol[i]   = '0;
      v_stamp[i] = '0;
    end
    ring_hd  = '0;
    loop_hd  = '0;
    loop_cnt = 0;
    thr      = REUSE_TOL_RESET;

    // Directed table. Rows with a typed word check the obvious cases;
    // the rest go through the model.
    add_row(mk_req(OPC_PLAY, 16'h0000, 1'b0, 16'h0000, 8'd0, 32'h0000_0000), 1,
            mk_evt(ACT_START, 4'd1, 16'h0000, 1'b0, 16'h0000));
    // Extremes: gain saturates at the top.
    add_row(mk_req(OPC_PLAY, 16'hFFFF, 1'b0, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF), 1,
            mk_evt(ACT_START, 4'd2, 16'hFFFF, 1'b0, 16'hFFFF));
    // Unity volume keeps the sample gain; looping start leaves the head put.
    add_row(mk_req(OPC_PLAY, 16'h0001, 1'b1, 16'h1000, 8'd100, 32'hFFFF_FFFF), 1,
            mk_evt(ACT_START, 4'd3, 16'h0001, 1'b1, 16'h1000));
    // Reuse with the request louder than the voice.
    add_row(mk_req(OPC_PLAY, 16'h0001, 1'b1, 16'h1000, 8'd105, 32'hFFFF_FFFF), -1, NO_EVT);
    // Age across the frame wrap is one: nothing stale, no word at all.
    add_row(mk_req(OPC_SWEEP, 16'hA5A5, 1'b1, 16'h5A5A, 8'hC3, 32'h0000_0000), 0, NO_EVT);
    add_row(mk_req(OPC_SWEEP, 16'h5A5A, 1'b0, 16'hA5A5, 8'h3C, 32'h0000_0001), -1, NO_EVT);
    // Pull fifteen voices into the looping list until the ring holds one.
    for (int i = 0; i < NUM_VOICES - 1; i++)
      add_row(mk_req(OPC_PLAY, SAMPLE_W'(16'h0100 + i), 1'b1, GAIN_W'($urandom), 8'd60,
                     32'd100), -1, NO_EVT);
    // Ring of one: one-shot dropped.
    add_row(mk_req(OPC_PLAY, 16'h7777, 1'b0, 16'h1000, 8'd100, 32'd100), 1,
            mk_evt(ACT_DROP, '0, '0, 1'b0, '0));
    // Volume difference equal to the threshold is no match, so dropped too.
    add_row(mk_req(OPC_PLAY, 16'h0100, 1'b1, 16'h1000, 8'd70, 32'd101), 1,
            mk_evt(ACT_DROP, '0, '0, 1'b0, '0));
    // Reuse with the voice louder than the request.
    add_row(mk_req(OPC_PLAY, 16'h0100, 1'b1, 16'h2345, 8'd51, 32'd101), -1, NO_EVT);
    // Sweep stops all but the refreshed voice: a long run of stop words.
    add_row(mk_req(OPC_SWEEP, 16'h0000, 1'b0, 16'h0000, 8'd0, 32'd102), -1, NO_EVT);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].req, dir_rows[i].n_typed, dir_rows[i].typed);
      pace_sender();
    end
    in_valid <= 1'b0;

    // Random phases, each under its own threshold, extremes included.
    thr_plan[0] = 8'd255;
    thr_plan[1] = 8'd0;
    thr_plan[2] = VOL_W'($urandom_range(2, 254));
    thr_plan[3] = 8'd1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= thr_plan[ph];
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      thr = thr_plan[ph];
      // Start one phase just short of the frame wrap.
      fr = (ph == 1) ? 32'hFFFF_FFF8 : FRAME_W'($urandom);
      for (int j = 0; j < 4; j++) begin
        pool_sid[j] = SAMPLE_W'($urandom);
        pool_vol[j] = VOL_W'($urandom);
      end
      if (ph == 2) squeeze_req <= 1'b1;
      repeat (PHASE_WORDS) begin
        pick_req(req);
        send_word(req, -1, NO_EVT);
        pace_sender();
      end
      in_valid <= 1'b0;
    end

    drain();
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
